// File: src/i2cmrs_pkg.sv
package i2cmrs_pkg;

  // Request queue geometry
  localparam int QUEUE_DEPTH = 8;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_IDX_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam int STEP_W = 3;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_POLL   = 2'd1,
    OP_EVENT  = 2'd2,
    OP_BUSERR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_START_SENT = 3'd0,
    EV_TX_MODE    = 3'd1,
    EV_BYTE_TXING = 3'd2,
    EV_BYTE_TXED  = 3'd3,
    EV_RX_MODE    = 3'd4,
    EV_BYTE_RXED  = 3'd5,
    EV_OTHER      = 3'd6
  } ev_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_START     = 3'd1,
    ACT_SEND      = 3'd2,
    ACT_NACK_STOP = 3'd3,
    ACT_STOP      = 3'd4,
    ACT_ACK_ON    = 3'd5,
    ACT_REINIT    = 3'd6
  } act_t;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_WORKING = 2'd1,
    ST_FINISH  = 2'd2,
    ST_ERROR   = 2'd3
  } xfer_state_t;

  localparam logic [1:0] STATUS_NONE     = 2'd0;
  localparam logic [1:0] STATUS_COMPLETE = 2'd1;
  localparam logic [1:0] STATUS_ERROR    = 2'd2;

  typedef struct packed {
    logic       is_read;
    logic [6:0] device;
    logic [7:0] reg_addr;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    op_t        op;
    req_t       req;
    ev_t        ev;
    logic [7:0] rx;
  } cmd_t;

endpackage

// File: src/i2c_master_request_sequencer.sv
// I2C master request sequencer: queues single-byte register reads and writes
// and walks each one through its bus sequence.
// Input channel (in_valid / in_stall): one item is a submit, a poll, a bus
// event or a bus error. Every item yields exactly one result item on the
// output channel (out_valid / out_stall) giving accept flag, bus action,
// byte to send, status and read byte.
// An accepted item passes through the command queue and the result register
// before out_valid rises. Throughput: one item per cycle while the output is
// not stalled; after a poll that starts a request the back end takes no item
// until the request is read out of the request RAM (registered read) into the
// current-request register.
// A two-entry command queue sits between the front end (accept, classify)
// and the back end (request FIFO, step sequencer, output register), so the
// front keeps taking items while a result waits in the output register.
// in_stall rises only when the command queue is full.
// Reset (rst_n low, synchronous): queues empty, transfer state empty,
// step zero, current request cleared to a write of zeros. No clearing pass.
// When out_stall is high the result holds; the back end stops, the command
// queue fills, and in_stall goes high after at most two more items.
module i2c_master_request_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic       in_is_read,
  input  logic [6:0] in_device_address,
  input  logic [7:0] in_register_address,
  input  logic [7:0] in_write_data,
  input  logic [2:0] in_event_code,
  input  logic [7:0] in_received_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_accepted,
  output logic [2:0] out_bus_action,
  output logic [7:0] out_action_byte,
  output logic [1:0] out_status,
  output logic [7:0] out_read_data
);
  import i2cmrs_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // front end: handshake, decode, command queue
  i2cmrs_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_is_read          (in_is_read),
    .in_device_address   (in_device_address),
    .in_register_address (in_register_address),
    .in_write_data       (in_write_data),
    .in_event_code       (in_event_code),
    .in_received_byte    (in_received_byte),
    .cmd_valid           (cmd_valid),
    .cmd                 (cmd),
    .cmd_pop             (cmd_pop)
  );

  // back end: request FIFO, transfer state, step sequencer, result register
  i2cmrs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accepted    (out_accepted),
    .out_bus_action  (out_bus_action),
    .out_action_byte (out_action_byte),
    .out_status      (out_status),
    .out_read_data   (out_read_data)
  );

endmodule

// File: src/i2cmrs_ram.sv
module i2cmrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/i2cmrs_front.sv
module i2cmrs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic              in_is_read,
  input  logic [6:0]        in_device_address,
  input  logic [7:0]        in_register_address,
  input  logic [7:0]        in_write_data,
  input  logic [2:0]        in_event_code,
  input  logic [7:0]        in_received_byte,
  output logic              cmd_valid,
  output i2cmrs_pkg::cmd_t  cmd,
  input  logic              cmd_pop
);
  import i2cmrs_pkg::*;

  cmd_t                  cmd_q_r [CMDQ_DEPTH];
  logic [CMDQ_IDX_W-1:0] wptr_r, wptr_nxt;
  logic [CMDQ_IDX_W-1:0] rptr_r, rptr_nxt;
  logic [CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t                  cmd_in;
  logic                  push;

  // Classify: decode the operation, fold unknown event codes into "other"
  always_comb begin
    cmd_in.op           = op_t'(in_operation);
    cmd_in.req.is_read  = in_is_read;
    cmd_in.req.device   = in_device_address;
    cmd_in.req.reg_addr = in_register_address;
    cmd_in.req.data     = in_write_data;
    cmd_in.rx           = in_received_byte;
    case (in_event_code)
      EV_START_SENT: cmd_in.ev = EV_START_SENT;
      EV_TX_MODE:    cmd_in.ev = EV_TX_MODE;
      EV_BYTE_TXING: cmd_in.ev = EV_BYTE_TXING;
      EV_BYTE_TXED:  cmd_in.ev = EV_BYTE_TXED;
      EV_RX_MODE:    cmd_in.ev = EV_RX_MODE;
      EV_BYTE_RXED:  cmd_in.ev = EV_BYTE_RXED;
      default:       cmd_in.ev = EV_OTHER;
    endcase
  end

  assign in_stall  = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = cmd_q_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = cmd_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q_r[wptr_r] <= cmd_in;
    end
  end

endmodule

// File: src/i2cmrs_back.sv
module i2cmrs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  i2cmrs_pkg::cmd_t  cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_accepted,
  output logic [2:0]        out_bus_action,
  output logic [7:0]        out_action_byte,
  output logic [1:0]        out_status,
  output logic [7:0]        out_read_data
);
  import i2cmrs_pkg::*;

  logic [QIDX_W-1:0] head_r, head_nxt;
  logic [QIDX_W-1:0] tail_r, tail_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  xfer_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  req_t              cur_r, cur_nxt;
  logic              load_pend_r, load_pend_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_accepted_r, out_accepted_nxt;
  act_t              out_action_r, out_action_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [7:0]        out_rd_r, out_rd_nxt;

  logic              fire;
  logic              ram_wr_en, ram_rd_en;
  req_t              ram_rd_data;
  logic              res_accepted;
  act_t              res_action;
  logic [7:0]        res_byte;
  logic [1:0]        res_status;
  logic [7:0]        res_rd;
  logic [7:0]        addr_byte;

  i2cmrs_ram #(
    .WIDTH ($bits(req_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_req_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (tail_r),
    .wr_data (cmd.req),
    .rd_en   (ram_rd_en),
    .rd_addr (head_r),
    .rd_data (ram_rd_data)
  );

  // A started request reaches cur_r through the RAM read register; hold off meanwhile.
  assign fire    = cmd_valid && !load_pend_r && (!out_valid_r || !out_stall);
  assign cmd_pop = fire;
  assign addr_byte = {cur_r.device, 1'b0};

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    state_nxt     = state_r;
    step_nxt      = step_r;
    cur_nxt       = load_pend_r ? ram_rd_data : cur_r;
    load_pend_nxt = 1'b0;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    res_accepted  = 1'b0;
    res_action    = ACT_NONE;
    res_byte      = '0;
    res_status    = STATUS_NONE;
    res_rd        = '0;

    if (fire) begin
      case (cmd.op)
        OP_SUBMIT: begin
          if (count_r < QCNT_W'(QUEUE_DEPTH)) begin
            ram_wr_en    = 1'b1;
            tail_nxt     = (tail_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
            count_nxt    = count_r + 1'b1;
            res_accepted = 1'b1;
          end
        end
        OP_POLL: begin
          if (count_r != '0) begin
            if (state_r == ST_EMPTY || state_r == ST_FINISH) begin
              ram_rd_en     = 1'b1;
              load_pend_nxt = 1'b1;
              head_nxt      = (head_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
              count_nxt     = count_r - 1'b1;
              state_nxt     = ST_WORKING;
              step_nxt      = '0;
              res_action    = ACT_START;
            end else if (state_r == ST_ERROR) begin
              state_nxt  = ST_EMPTY;
              step_nxt   = '0;
              res_action = ACT_REINIT;
            end
          end
        end
        OP_EVENT: begin
          if (!cur_r.is_read) begin
            if (step_r == 3'd0 && cmd.ev == EV_START_SENT) begin
              step_nxt = 3'd1; res_action = ACT_SEND; res_byte = addr_byte;
            end else if (step_r == 3'd1 && cmd.ev == EV_TX_MODE) begin
              step_nxt = 3'd2; res_action = ACT_SEND; res_byte = cur_r.reg_addr;
            end else if (step_r == 3'd2 && cmd.ev == EV_BYTE_TXING) begin
              step_nxt = 3'd3; res_action = ACT_SEND; res_byte = cur_r.data;
            end else if (step_r == 3'd3 && cmd.ev == EV_BYTE_TXED) begin
              step_nxt   = '0;
              state_nxt  = ST_FINISH;
              res_action = ACT_STOP;
              res_status = STATUS_COMPLETE;
            end else if (cmd.ev != EV_BYTE_TXED) begin
              state_nxt  = ST_ERROR;
              step_nxt   = '0;
              res_status = STATUS_ERROR;
            end
          end else begin
            if (step_r == 3'd0 && cmd.ev == EV_START_SENT) begin
              step_nxt = 3'd1; res_action = ACT_SEND; res_byte = addr_byte;
            end else if (step_r == 3'd1 && cmd.ev == EV_TX_MODE) begin
              step_nxt = 3'd2; res_action = ACT_SEND; res_byte = cur_r.reg_addr;
            end else if (step_r == 3'd2 && cmd.ev == EV_BYTE_TXED) begin
              step_nxt = 3'd3; res_action = ACT_START;
            end else if (step_r == 3'd3 && cmd.ev == EV_START_SENT) begin
              step_nxt   = 3'd4;
              res_action = ACT_SEND;
              res_byte   = {cur_r.device, 1'b1};
            end else if (step_r == 3'd4 && cmd.ev == EV_RX_MODE) begin
              step_nxt = 3'd5; res_action = ACT_NACK_STOP;
            end else if (step_r == 3'd5 && cmd.ev == EV_BYTE_RXED) begin
              step_nxt   = '0;
              state_nxt  = ST_FINISH;
              res_action = ACT_ACK_ON;
              res_status = STATUS_COMPLETE;
              res_rd     = cmd.rx;
            end else if (cmd.ev != EV_BYTE_TXED) begin
              state_nxt  = ST_ERROR;
              step_nxt   = '0;
              res_status = STATUS_ERROR;
            end
          end
        end
        default: begin
          // bus error interrupt
          state_nxt  = ST_ERROR;
          step_nxt   = '0;
          res_status = STATUS_ERROR;
        end
      endcase
    end

    // output register
    out_valid_nxt    = fire ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    out_accepted_nxt = fire ? res_accepted : out_accepted_r;
    out_action_nxt   = fire ? res_action : out_action_r;
    out_byte_nxt     = fire ? res_byte : out_byte_r;
    out_status_nxt   = fire ? res_status : out_status_r;
    out_rd_nxt       = fire ? res_rd : out_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      state_r     <= ST_EMPTY;
      step_r      <= '0;
      cur_r       <= '0;
      load_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cur_r       <= cur_nxt;
      load_pend_r <= load_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_accepted_r <= out_accepted_nxt;
    out_action_r   <= out_action_nxt;
    out_byte_r     <= out_byte_nxt;
    out_status_r   <= out_status_nxt;
    out_rd_r       <= out_rd_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_accepted_r;
  assign out_bus_action  = out_action_r;
  assign out_action_byte = out_byte_r;
  assign out_status      = out_status_r;
  assign out_read_data   = out_rd_r;

endmodule

// File: src/i2cmrs_checker.sv
module i2cmrs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_accepted,
  input logic [2:0] out_bus_action,
  input logic [7:0] out_action_byte,
  input logic [1:0] out_status,
  input logic [7:0] out_read_data
);
  import i2cmrs_pkg::*;

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bus_action)
      && $stable(out_action_byte) && $stable(out_status) && $stable(out_read_data))
    else $error("stalled result changed");

  // a queued submit causes no bus action and no status
  a_accept_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_bus_action == ACT_NONE && out_status == STATUS_NONE)
    else $error("accepted submit carries bus activity");

  // a byte only travels with a send action
  a_byte_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action_byte != 8'd0 |-> out_bus_action == ACT_SEND)
    else $error("action byte without send");

  // read data only with a completed read
  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_data != 8'd0 |->
      out_bus_action == ACT_ACK_ON && out_status == STATUS_COMPLETE)
    else $error("read data outside read completion");

endmodule

bind i2c_master_request_sequencer i2cmrs_checker u_i2cmrs_checker (.*);
